/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, operation codes and the structs that pass between cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Number of slots in the chain (2 to 15).
    localparam int QUEUE_DEPTH = 8;

    // Width of the entry counter, wide enough to hold QUEUE_DEPTH itself.
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int DATA_W = 32;
    localparam int PRIO_W = 32;
    localparam int OCC_W  = 4;

    // Operation codes carried on func.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Command broadcast to every cell in a cycle.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [DATA_W-1:0]        data;
        logic signed [PRIO_W-1:0] prio;
    } cell_cmd_t;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic                     valid;
        logic                     gt;
        logic [DATA_W-1:0]        data;
        logic signed [PRIO_W-1:0] prio;
    } cell_link_t;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast priority and takes its own value from a neighbor or the command.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::cell_link_t prev,
    input  spq_pkg::cell_link_t next,
    output spq_pkg::cell_link_t self
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [spq_pkg::DATA_W-1:0]       data_reg;
    logic [spq_pkg::DATA_W-1:0]       data_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;
    logic                             gt;

    // The new entry goes in front of this one when its priority is strictly higher.
    assign gt = valid_reg && (cmd.prio > prio_reg);

    assign self.valid = valid_reg;
    assign self.gt    = gt;
    assign self.data  = data_reg;
    assign self.prio  = prio_reg;

    // Select this slot's next content.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        prio_next  = prio_reg;
        if (cmd.rem)
        begin
            valid_next = next.valid;
            data_next  = next.data;
            prio_next  = next.prio;
        end
        else if (cmd.ins)
        begin
            if (prev.gt)
            begin
                valid_next = prev.valid;
                data_next  = prev.data;
                prio_next  = prev.prio;
            end
            else if ((gt || !valid_reg) && prev.valid)
            begin
                valid_next = 1'b1;
                data_next  = cmd.data;
                prio_next  = cmd.prio;
            end
        end
    end

    // The valid flag is control state; the entry itself needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

/* rtl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted by descending signed priority in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one operation per transaction:
// func selects insert or remove of the highest-priority entry; in_data and
// in_priority are used on insert. Equal priorities leave in arrival order.
// The output channel (out_valid/out_ready) returns one transaction per input
// with ok, out_data, out_priority (zero unless a remove succeeded) and the
// occupancy after the operation. An insert into a full queue or a remove
// from an empty queue returns ok low and leaves the queue unchanged.
// Every cell compares and shifts in the same cycle, and the result of an
// operation is loaded into the output register in the cycle after it is
// accepted. One transaction per cycle is sustained while the receiver
// keeps out_ready high. When the receiver
// stalls, the result stays in the output register and in_ready drops until
// it is taken. Reset empties the queue and clears out_valid; no clearing
// pass is needed, and the queue accepts transactions right after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [spq_pkg::DATA_W-1:0]        in_data,
    input  logic signed [spq_pkg::PRIO_W-1:0] in_priority,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic [spq_pkg::DATA_W-1:0]        out_data,
    output logic signed [spq_pkg::PRIO_W-1:0] out_priority,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);

    localparam int D = spq_pkg::QUEUE_DEPTH;

    spq_pkg::cell_cmd_t  cmd;
    spq_pkg::cell_link_t links [D];
    spq_pkg::cell_link_t head_link;
    spq_pkg::cell_link_t tail_link;
    logic [D-1:0]        valid_vec;

    logic                              accept;
    logic                              full;
    logic                              empty;
    logic                              do_ins;
    logic                              do_rem;
    logic [spq_pkg::CNT_W-1:0]         count_reg;
    logic [spq_pkg::CNT_W-1:0]         count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              ok_reg;
    logic [spq_pkg::DATA_W-1:0]        data_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::OCC_W-1:0]         occ_reg;

    // Handshake: a new transaction enters when the output register is free or drains.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign full   = links[D-1].valid;
    assign empty  = !links[0].valid;
    assign do_ins = accept && (func == spq_pkg::FUNC_INSERT) && !full;
    assign do_rem = accept && (func == spq_pkg::FUNC_REMOVE) && !empty;

    assign cmd.ins  = do_ins;
    assign cmd.rem  = do_rem;
    assign cmd.data = in_data;
    assign cmd.prio = in_priority;

    // Boundary links: the head always accepts the new entry, past the tail is empty.
    assign head_link.valid = 1'b1;
    assign head_link.gt    = 1'b0;
    assign head_link.data  = '0;
    assign head_link.prio  = '0;
    assign tail_link.valid = 1'b0;
    assign tail_link.gt    = 1'b0;
    assign tail_link.data  = '0;
    assign tail_link.prio  = '0;

    // The chain of slots.
    for (genvar i = 0; i < D; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .prev  ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
            .next  ((i == D - 1) ? tail_link : links[(i == D - 1) ? D - 1 : i + 1]),
            .self  (links[i])
        );
        assign valid_vec[i] = links[i].valid;
    end

    // Entry count after this cycle.
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + spq_pkg::CNT_W'(1);
        end
        else if (do_rem)
        begin
            count_next = count_reg - spq_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result register, loaded on every accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg   <= do_ins || do_rem;
            data_reg <= do_rem ? links[0].data : '0;
            prio_reg <= do_rem ? links[0].prio : '0;
            occ_reg  <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign out_data     = data_reg;
    assign out_priority = prio_reg;
    assign occupancy    = occ_reg;

    // Occupied slots always form an unbroken run from the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + D'(1)) & valid_vec) == '0)
        else $error("Occupied slots are not contiguous from the head.");

    // The counter agrees with the number of occupied cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'($countones(valid_vec)) == 32'(count_reg))
        else $error("Entry count disagrees with occupied cells.");

    // A successful remove hands out the entry that sat at the head.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_rem |=> (ok && out_data == $past(links[0].data)
                    && out_priority == $past(links[0].prio)))
        else $error("Remove result does not match the head entry.");

    // The head never holds a lower priority than its successor.
    assert property (@(posedge clk) disable iff (!rst_n)
        links[1].valid |-> (links[0].prio >= links[1].prio))
        else $error("Head and second slot are out of order.");

endmodule
